// File: hw/rtl/homogeneous_point_vector_transform_defines.svh
// Assertion helpers shared by the transform block.
`ifndef HOMOGENEOUS_POINT_VECTOR_TRANSFORM_DEFINES_SVH
`define HOMOGENEOUS_POINT_VECTOR_TRANSFORM_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define HPVT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property must hold in the cycle after a condition.
`define HPVT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hw/rtl/hpvt_pkg.sv
`timescale 1ns / 1ps
package hpvt_pkg;
  localparam int unsigned DefaultFractionBits = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned NumCorners = 8;

  typedef enum logic [1:0] {
    ActPoint  = 2'd0,
    ActVector = 2'd1,
    ActNormal = 2'd2,
    ActBox    = 2'd3
  } action_e;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic fault;
    logic ovf;
  } flags_t;

  localparam logic signed [31:0] Max32 = 32'sh7fffffff;
  localparam logic signed [31:0] Min32 = 32'sh80000000;
endpackage

// File: hw/rtl/hpvt_lane.sv
`timescale 1ns / 1ps
// One corner lane: row sums, rounding, fixed-point divide by w, saturation.
// A new operand set is taken every cycle in which en_i is high.
module hpvt_lane import hpvt_pkg::*; #(
  parameter int unsigned FractionBits = DefaultFractionBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [1:0]       action_i,
  input  coord_t           px_i,
  input  coord_t           py_i,
  input  coord_t           pz_i,
  input  coord_t           coef_i [4][4],
  output coord_t           res_o  [3],
  output flags_t           flags_o
);
  localparam int unsigned PW = 64;
  localparam int unsigned SW = 67;
  localparam int unsigned RW = SW - FractionBits;
  localparam int unsigned QW = 33 + FractionBits;
  // Divider steps, one restoring step per stage, quotient of QW+1 bits.
  localparam int unsigned DivSteps = QW + 1;
  // Dividend bits above the quotient window start in the remainder.
  localparam int unsigned TopShift = QW - FractionBits;

  // Stage 1: sixteen products.
  logic signed [PW-1:0] prod_q [4][4];
  logic [1:0]           act1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act1_q <= action_i;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          logic signed [31:0] a;
          logic signed [31:0] m;
          m = coef_i[r][c];
          if (action_i == ActNormal) m = coef_i[c][r];
          if (c == 0) a = px_i;
          else if (c == 1) a = py_i;
          else if (c == 2) a = pz_i;
          else a = (action_i == ActPoint || action_i == ActBox) ?
                   (32'sd1 <<< FractionBits) : 32'sd0;
          if (c == 3 && action_i == ActNormal) m = 32'sd0;
          prod_q[r][c] <= PW'(m) * PW'(a);
        end
      end
    end
  end

  // Stage 2: exact sums, rounded half up.
  logic signed [RW-1:0] v_q [4];
  logic [1:0]           act2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act2_q <= act1_q;
      for (int r = 0; r < 4; r++) begin
        logic signed [SW-1:0] s;
        s = SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2])
          + SW'(prod_q[r][3]) + (SW'(1) <<< (FractionBits - 1));
        v_q[r] <= RW'(s >>> FractionBits);
      end
    end
  end

  // Stage 3: magnitudes and special cases for the divider.
  typedef struct packed {
    logic [RW-1:0] num;
    logic [RW-1:0] den;
    logic          neg;
    logic          zero;
    logic          pass;   // no divide: direct saturate
    logic signed [RW-1:0] raw;
  } dv_t;
  dv_t dv_q [3];
  logic    fault3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        logic point;
        logic signed [RW-1:0] n;
        logic signed [RW-1:0] d;
        point = (act2_q == ActPoint) || (act2_q == ActBox);
        n = v_q[k];
        d = v_q[3];
        dv_q[k].raw  <= n;
        dv_q[k].num  <= n[RW-1] ? RW'(-n) : RW'(n);
        dv_q[k].den  <= d[RW-1] ? RW'(-d) : RW'(d);
        dv_q[k].neg  <= n[RW-1] ^ d[RW-1];
        dv_q[k].zero <= point && (d == '0);
        dv_q[k].pass <= !point || (d == (RW'(1) <<< FractionBits));
      end
      fault3_q <= ((act2_q == ActPoint) || (act2_q == ActBox)) && (v_q[3] == '0);
    end
  end

  // Divider pipeline: quotient of (num << (F+1)) / den, one bit per stage.
  // The dividend bits above the quotient window are loaded into the remainder
  // up front; if they already reach the divisor, the quotient cannot fit in
  // the window and the result saturates.
  typedef struct packed {
    logic [RW-1:0]        rem;
    logic [DivSteps-1:0]  qt;
    logic [RW-1:0]        den;
    logic                 neg;
    logic                 zero;
    logic                 pass;
    logic                 big;
    logic signed [RW-1:0] raw;
  } st_t;
  st_t    pipe_q [3][DivSteps+1];
  logic   fault_p_q [DivSteps+1];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fault_p_q[0] <= fault3_q;
      for (int k = 0; k < 3; k++) begin
        pipe_q[k][0].rem  <= dv_q[k].num >> TopShift;
        pipe_q[k][0].qt   <= {dv_q[k].num[TopShift-1:0], {(FractionBits+1){1'b0}}};
        pipe_q[k][0].den  <= dv_q[k].den;
        pipe_q[k][0].neg  <= dv_q[k].neg;
        pipe_q[k][0].zero <= dv_q[k].zero;
        pipe_q[k][0].pass <= dv_q[k].pass || dv_q[k].zero;
        pipe_q[k][0].big  <= (dv_q[k].num >> TopShift) >= dv_q[k].den;
        pipe_q[k][0].raw  <= dv_q[k].raw;
      end
      for (int s = 0; s < DivSteps; s++) begin
        fault_p_q[s+1] <= fault_p_q[s];
        for (int k = 0; k < 3; k++) begin
          st_t cur;
          st_t nxt;
          logic [RW+1:0] tr;
          cur = pipe_q[k][s];
          nxt = cur;
          // Restoring step: shift in the next dividend bit, subtract if it fits.
          tr = {1'b0, cur.rem, cur.qt[DivSteps-1]} - {2'b00, cur.den};
          if (!tr[RW+1]) begin
            nxt.rem = tr[RW-1:0];
            nxt.qt  = {cur.qt[DivSteps-2:0], 1'b1};
          end else begin
            nxt.rem = {cur.rem[RW-2:0], cur.qt[DivSteps-1]};
            nxt.qt  = {cur.qt[DivSteps-2:0], 1'b0};
          end
          pipe_q[k][s+1] <= nxt;
        end
      end
    end
  end

  // Final stage: select, round, saturate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_o <= '0;
    end else if (en_i) begin
      logic ov;
      ov = 1'b0;
      for (int k = 0; k < 3; k++) begin
        st_t f;
        logic [DivSteps:0] mag;
        f = pipe_q[k][DivSteps];
        // The quotient carries one extra fraction bit, so adding one and
        // dropping it rounds half away from zero on the magnitude.
        mag = ({1'b0, f.qt} + 1'b1) >> 1;
        if (f.zero) begin
          res_o[k] <= (f.raw == '0) ? 32'sd0 : (f.raw[RW-1] ? Min32 : Max32);
        end else if (f.pass) begin
          if (f.raw > RW'(Max32)) begin
            res_o[k] <= Max32; ov = 1'b1;
          end else if (f.raw < RW'(Min32)) begin
            res_o[k] <= Min32; ov = 1'b1;
          end else begin
            res_o[k] <= 32'(f.raw);
          end
        end else if (f.raw == '0) begin
          res_o[k] <= 32'sd0;
        end else if (!f.neg) begin
          if (f.big || mag > (DivSteps+1)'(32'h7fffffff)) begin
            res_o[k] <= Max32; ov = 1'b1;
          end else begin
            res_o[k] <= 32'(mag);
          end
        end else begin
          if (f.big || mag > (DivSteps+1)'(33'h080000000)) begin
            res_o[k] <= Min32; ov = 1'b1;
          end else begin
            res_o[k] <= 32'(-mag);
          end
        end
      end
      flags_o.ovf   <= ov;
      flags_o.fault <= fault_p_q[DivSteps];
    end
  end
endmodule

// File: hw/rtl/hpvt_merge.sv
`timescale 1ns / 1ps
// Combines the eight lane results: in box mode min/max over corners and OR of flags, otherwise lane zero is forwarded.
module hpvt_merge import hpvt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   box_i,
  input  coord_t res_i   [NumCorners][3],
  input  flags_t flags_i [NumCorners],
  output coord_t mn_o    [3],
  output coord_t mx_o    [3],
  output flags_t flags_o
);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_o <= '0;
    end else if (en_i) begin
      flags_t f;
      f = box_i ? '0 : flags_i[0];
      for (int k = 0; k < 3; k++) begin
        coord_t lo;
        coord_t hi;
        lo = res_i[0][k];
        hi = res_i[0][k];
        for (int i = 1; i < NumCorners; i++) begin
          if (res_i[i][k] < lo) lo = res_i[i][k];
          if (res_i[i][k] > hi) hi = res_i[i][k];
        end
        mn_o[k] <= box_i ? lo : res_i[0][k];
        mx_o[k] <= box_i ? hi : 32'sd0;
      end
      if (box_i) begin
        for (int i = 0; i < NumCorners; i++) f = f | flags_i[i];
      end
      flags_o <= f;
    end
  end
endmodule

// File: hw/rtl/homogeneous_point_vector_transform.sv
`timescale 1ns / 1ps
// Homogeneous 4x4 transform of points, vectors, normals and boxes, Q16.16.
// Input beats arrive on s_axis (tuser = action, tdata = six coordinates).
// Each beat yields exactly one output beat on m_axis with six coordinates
// in tdata and the divide fault and overflow flags in tuser.
// The matrix sits in eight 64-bit registers written over the cfg channel,
// which is always ready; write it only while the block is idle.
// Eight lanes, one per box corner, run in parallel; for the other actions
// lane zero carries the item and the merge stage forwards it.
// The whole datapath is one pipeline that advances when the output
// register is free or being drained, so one beat per cycle is sustained.
// The pipeline depth is set mostly by the divider, which retires one
// quotient bit per stage.
// When the receiver stalls, the pipeline freezes and s_axis_tready drops.
// Reset loads the identity matrix and empties the pipeline.
`include "homogeneous_point_vector_transform_defines.svh"
module homogeneous_point_vector_transform import hpvt_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DefaultFractionBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // in_x, in_y, in_z, in_x_max, in_y_max, in_z_max from bit 0 up
  input  logic [191:0]   s_axis_tdata,
  // action
  input  logic [1:0]     s_axis_tuser,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // out_x, out_y, out_z, out_x_max, out_y_max, out_z_max from bit 0 up
  output logic [191:0]   m_axis_tdata,
  // divide_fault, overflow from bit 0 up
  output logic [1:0]     m_axis_tuser,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [63:0]    cfg_data_i
);
  // Products, sum, divider setup, divider entry, one stage per quotient bit,
  // lane output and merge register.
  localparam int unsigned Depth = 3 + 1 + (34 + FRACTION_BITS) + 1 + 1;

  logic [63:0] mreg_q [NumRegs];
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        if (i == 0 || i == 5) mreg_q[i] <= 64'd1 << FRACTION_BITS;
        else if (i == 2 || i == 7) mreg_q[i] <= 64'd1 << (32 + FRACTION_BITS);
        else mreg_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      mreg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  coord_t coef [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = mreg_q[r*2 + c/2][(c%2)*32 +: 32];
      end
    end
  end

  // Pipeline advances when the output slot is empty or being taken.
  logic en;
  logic [Depth-1:0] vld_q;
  logic [1:0]       act_sh_q [Depth];
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      act_sh_q[0] <= s_axis_tuser;
      for (int i = 1; i < Depth; i++) act_sh_q[i] <= act_sh_q[i-1];
    end
  end

  coord_t lo [3];
  coord_t hi [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo[k] = s_axis_tdata[k*32 +: 32];
      hi[k] = s_axis_tdata[(k+3)*32 +: 32];
    end
  end

  coord_t res   [NumCorners][3];
  flags_t flags [NumCorners];
  for (genvar i = 0; i < NumCorners; i++) begin : g_lane
    logic [1:0] act_l;
    assign act_l = (s_axis_tuser == ActBox) ? ActPoint : s_axis_tuser;
    hpvt_lane #(.FractionBits(FRACTION_BITS)) u_lane (
      .clk_i,
      .rst_ni,
      .en_i     (en),
      .action_i (act_l),
      .px_i     (((i & 1) != 0) ? hi[0] : lo[0]),
      .py_i     (((i & 2) != 0) ? hi[1] : lo[1]),
      .pz_i     (((i & 4) != 0) ? hi[2] : lo[2]),
      .coef_i   (coef),
      .res_o    (res[i]),
      .flags_o  (flags[i])
    );
  end

  coord_t mn [3];
  coord_t mx [3];
  flags_t fl;
  hpvt_merge u_merge (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .box_i   (act_sh_q[Depth-2] == ActBox),
    .res_i   (res),
    .flags_i (flags),
    .mn_o    (mn),
    .mx_o    (mx),
    .flags_o (fl)
  );

  assign m_axis_tdata = {mx[2], mx[1], mx[0], mn[2], mn[1], mn[0]};
  assign m_axis_tuser = {fl.ovf, fl.fault};

  `HPVT_ASSERT(a_ready, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready,
    "input accepted while output stalled")
  `HPVT_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    $stable(m_axis_tdata), "output changed under stall")
  `HPVT_ASSERT(a_fault, clk_i, rst_ni,
    m_axis_tvalid && (act_sh_q[Depth-1] == ActVector || act_sh_q[Depth-1] == ActNormal)
    |-> !m_axis_tuser[0], "divide fault outside point mode")
endmodule
